// ===== sv/cia_pkg.sv =====
// Shared types and constants for the checked integer ALU.
`default_nettype none
package cia_pkg;

  localparam int unsigned DATA_W = 64;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_OR  = 4'd5,
    OP_AND = 4'd6,
    OP_XOR = 4'd7,
    OP_NOT = 4'd8,
    OP_NEG = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // Operands as they leave the prepare stage.
  typedef struct packed {
    op_e              op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ua;
    logic [DATA_W-1:0] ub;
  } front_t;

  // What rides along the divider besides the division itself.
  typedef struct packed {
    op_e               op;
    logic              an;
    logic              qneg;
    logic              ubz;
    logic              div_ovf;
    logic [DATA_W-1:0] res;
    status_e           st;
  } div_side_t;

endpackage
`default_nettype wire

// ===== sv/checked_integer_alu_unit.sv =====
// Top level of the checked signed 64-bit integer ALU.
// Takes one item per clock while the output side does not stall and returns one result per
// item, in order. The divider produces one quotient bit per pipeline stage over 64 stages;
// every operation travels the same path, so results keep their order. The whole pipeline
// advances together and holds while a finished result waits at the output register, so
// in_ready_o drops only when that register is full and not being taken.
`default_nettype none
module checked_integer_alu_unit
  import cia_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [3:0]         operation_i,
  input  wire logic signed [63:0] operand_a_i,
  input  wire logic signed [63:0] operand_b_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [63:0]      result_o,
  output logic [1:0]              status_o
);

  logic              en;
  logic              v0_q, vp_q, ov_q;
  op_e               op0_q;
  logic [DATA_W-1:0] a0_q, b0_q;
  front_t            fp_q;
  front_t            fp_d;

  logic                mv;
  front_t              mf;
  logic [2*DATA_W-1:0] prod;
  div_side_t           side_d;

  logic              dv;
  logic [DATA_W-1:0] quo, rem;
  div_side_t         dside;

  logic [DATA_W-1:0] res_d, res_q;
  status_e           st_d, st_q;

  assign en         = !ov_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      vp_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      vp_q <= v0_q;
      ov_q <= dv;
    end
  end

  always_comb begin
    fp_d.op = op0_q;
    fp_d.a  = a0_q;
    fp_d.b  = b0_q;
    fp_d.ua = a0_q[DATA_W-1] ? (DATA_W'(0) - a0_q) : a0_q;
    fp_d.ub = b0_q[DATA_W-1] ? (DATA_W'(0) - b0_q) : b0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= op_e'(operation_i);
      a0_q  <= $unsigned(operand_a_i);
      b0_q  <= $unsigned(operand_b_i);
      fp_q  <= fp_d;
      res_q <= res_d;
      st_q  <= st_d;
    end
  end

  cia_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp_q),
    .front_i (fp_q),
    .valid_o (mv),
    .front_o (mf),
    .prod_o  (prod)
  );

  // Everything but division and modulo is settled here and rides the divider.
  always_comb begin
    logic              an, bn, neg;
    logic [DATA_W-1:0] sum, lim, pabs;
    an  = mf.a[DATA_W-1];
    bn  = mf.b[DATA_W-1];
    neg = an ^ bn;
    sum = mf.a + mf.b;
    lim = neg ? MOST_NEG : MOST_POS;
    pabs = prod[DATA_W-1:0];
    side_d.op      = mf.op;
    side_d.an      = an;
    side_d.qneg    = neg;
    side_d.ubz     = (mf.ub == '0);
    side_d.div_ovf = (mf.a == MOST_NEG) && (mf.b == '1);
    side_d.res     = '0;
    side_d.st      = ST_OK;
    case (mf.op)
      OP_ADD: begin
        if (an == bn && sum[DATA_W-1] != an) side_d.st = ST_OVF;
        else side_d.res = sum;
      end
      OP_SUB: side_d.res = mf.a - mf.b;
      OP_MUL: begin
        if (prod[2*DATA_W-1:DATA_W] != '0 || pabs > lim) side_d.st = ST_OVF;
        else side_d.res = neg ? (DATA_W'(0) - pabs) : pabs;
      end
      OP_OR:  side_d.res = mf.a | mf.b;
      OP_AND: side_d.res = mf.a & mf.b;
      OP_XOR: side_d.res = mf.a ^ mf.b;
      OP_NOT: side_d.res = ~mf.a;
      OP_NEG: begin
        if (mf.a == MOST_NEG) side_d.st = ST_OVF;
        else side_d.res = DATA_W'(0) - mf.a;
      end
      default: ;
    endcase
  end

  cia_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mv),
    .ua_i    (mf.ua),
    .ub_i    (mf.ub),
    .side_i  (side_d),
    .valid_o (dv),
    .quo_o   (quo),
    .rem_o   (rem),
    .side_o  (dside)
  );

  always_comb begin
    res_d = dside.res;
    st_d  = dside.st;
    case (dside.op)
      OP_DIV: begin
        res_d = '0;
        if (dside.ubz) st_d = ST_DIVZ;
        else if (dside.div_ovf) st_d = ST_OVF;
        else res_d = dside.qneg ? (DATA_W'(0) - quo) : quo;
      end
      OP_MOD: begin
        res_d = '0;
        if (dside.ubz) st_d = ST_DIVZ;
        else res_d = dside.an ? (DATA_W'(0) - rem) : rem;
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign result_o    = $signed(res_q);
  assign status_o    = st_q;

endmodule
`default_nettype wire

// ===== sv/cia_mul.sv =====
// Three-stage unsigned multiplier built from four 32x32 partial products.
`default_nettype none
module cia_mul
  import cia_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire front_t              front_i,
  output logic                     valid_o,
  output front_t                   front_o,
  output logic [2*DATA_W-1:0]      prod_o
);

  localparam int unsigned HW = DATA_W / 2;

  logic              v1_q, v2_q, v3_q;
  front_t            fr1_q, fr2_q, fr3_q;
  logic [DATA_W-1:0] pll1_q, plh1_q, phl1_q, phh1_q;
  logic [DATA_W-1:0] pll2_q, phh2_q;
  logic [DATA_W:0]   mid2_q;
  logic [2*DATA_W-1:0] prod3_q;
  logic [2*DATA_W-1:0] prod3_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign prod3_d = {phh2_q, pll2_q} + ({{(DATA_W-1){1'b0}}, mid2_q} << HW);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fr1_q   <= front_i;
      pll1_q  <= front_i.ua[HW-1:0]      * front_i.ub[HW-1:0];
      plh1_q  <= front_i.ua[HW-1:0]      * front_i.ub[DATA_W-1:HW];
      phl1_q  <= front_i.ua[DATA_W-1:HW] * front_i.ub[HW-1:0];
      phh1_q  <= front_i.ua[DATA_W-1:HW] * front_i.ub[DATA_W-1:HW];
      fr2_q   <= fr1_q;
      pll2_q  <= pll1_q;
      phh2_q  <= phh1_q;
      mid2_q  <= {1'b0, plh1_q} + {1'b0, phl1_q};
      fr3_q   <= fr2_q;
      prod3_q <= prod3_d;
    end
  end

  assign valid_o = v3_q;
  assign front_o = fr3_q;
  assign prod_o  = prod3_q;

endmodule
`default_nettype wire

// ===== sv/cia_div.sv =====
// Restoring unsigned divider, one quotient bit per pipeline stage.
`default_nettype none
module cia_div
  import cia_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DATA_W-1:0] ua_i,
  input  wire logic [DATA_W-1:0] ub_i,
  input  wire div_side_t         side_i,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      quo_o,
  output logic [DATA_W-1:0]      rem_o,
  output div_side_t              side_o
);

  logic              v_q   [0:DATA_W];
  logic [DATA_W-1:0] rem_q [0:DATA_W];
  logic [DATA_W-1:0] quo_q [0:DATA_W];
  logic [DATA_W-1:0] dv_q  [0:DATA_W];
  div_side_t         sd_q  [0:DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      quo_q[0] <= ua_i;
      dv_q[0]  <= ub_i;
      sd_q[0]  <= side_i;
    end
  end

  for (genvar k = 0; k < DATA_W; k++) begin : g_step
    logic [DATA_W:0]   t;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] rem_d;

    // The running remainder stays below the divisor, so it fits one word.
    assign t     = {rem_q[k], quo_q[k][DATA_W-1]};
    assign diff  = t - {1'b0, dv_q[k]};
    assign ge    = !diff[DATA_W];
    assign rem_d = ge ? diff[DATA_W-1:0] : t[DATA_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        quo_q[k+1] <= {quo_q[k][DATA_W-2:0], ge};
        dv_q[k+1]  <= dv_q[k];
        sd_q[k+1]  <= sd_q[k];
      end
    end
  end

  assign valid_o = v_q[DATA_W];
  assign quo_o   = quo_q[DATA_W];
  assign rem_o   = rem_q[DATA_W];
  assign side_o  = sd_q[DATA_W];

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the checked integer ALU: random and directed items against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import cia_pkg::*;

  class alu_scoreboard;
    logic [63:0] exp_res_q[$];
    logic [1:0]  exp_st_q[$];
    int          errors = 0;

    function void note_input(logic [3:0] op, logic [63:0] a, logic [63:0] b);
      logic        an, bn, neg;
      logic [63:0] ua, ub, res, s;
      logic [127:0] p;
      logic [1:0]  st;
      an = a[63];
      bn = b[63];
      ua = an ? -a : a;
      ub = bn ? -b : b;
      res = '0;
      st = ST_OK;
      case (op)
        OP_ADD: begin
          s = a + b;
          if (an == bn && s[63] != an) st = ST_OVF;
          else res = s;
        end
        OP_SUB: res = a - b;
        OP_MUL: begin
          neg = an ^ bn;
          p = ua * ub;
          if (p > (neg ? 128'h8000_0000_0000_0000 : 128'h7fff_ffff_ffff_ffff)) st = ST_OVF;
          else res = neg ? -p[63:0] : p[63:0];
        end
        OP_DIV: begin
          if (ub == 0) st = ST_DIVZ;
          else if (a == MOST_NEG && b == '1) st = ST_OVF;
          else res = (an ^ bn) ? -(ua / ub) : ua / ub;
        end
        OP_MOD: begin
          if (ub == 0) st = ST_DIVZ;
          else res = an ? -(ua % ub) : ua % ub;
        end
        OP_OR:  res = a | b;
        OP_AND: res = a & b;
        OP_XOR: res = a ^ b;
        OP_NOT: res = ~a;
        OP_NEG: begin
          if (a == MOST_NEG) st = ST_OVF;
          else res = -a;
        end
        default: ;
      endcase
      if (st != ST_OK) res = '0;
      exp_res_q.push_back(res);
      exp_st_q.push_back(st);
    endfunction

    function void check_result(logic [63:0] res, logic [1:0] st);
      logic [63:0] er;
      logic [1:0]  es;
      if (exp_res_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h st %0d", $time, res, st);
        errors++;
        return;
      end
      er = exp_res_q.pop_front();
      es = exp_st_q.pop_front();
      if (res !== er) begin
        $display("%0t: result mismatch, expected %h, got %h", $time, er, res);
        errors++;
      end
      if (st !== es) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, es, st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [3:0] operation_i = '0;
  logic signed [63:0] operand_a_i = '0;
  logic signed [63:0] operand_b_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [63:0] result_o;
  logic [1:0] status_o;

  alu_scoreboard scb = new();
  int cycle_count = 0;
  bit calm = 1'b0;

  always #5 clk_i = ~clk_i;

  checked_integer_alu_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .operand_a_i,
    .operand_b_i, .out_valid_o, .out_ready_i, .result_o, .status_o
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Accepted items are recorded and results checked on the same sampled edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      scb.note_input(operation_i, operand_a_i, operand_b_i);
    if (rst_ni && out_valid_o && out_ready_i)
      scb.check_result(result_o, status_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 6);
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '1;
      3: return '0;
      4: return 64'd1;
      5: return {{56{1'($urandom_range(1))}}, 8'($urandom)};
      6: return {32'($urandom), 32'($urandom)} >> $urandom_range(63);
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (scb.exp_res_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [3:0] op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed corners: overflow edges, zero divisors, unused codes.
    send_item(OP_ADD, MOST_POS, 64'd1);
    send_item(OP_ADD, MOST_NEG, '1);
    send_item(OP_ADD, -64'd4, MOST_NEG + 64'd4);
    send_item(OP_SUB, MOST_NEG, 64'd1);
    send_item(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
    send_item(OP_MUL, 64'h1_0000_0000, -64'h8000_0000);
    send_item(OP_MUL, MOST_NEG, '1);
    send_item(OP_MUL, MOST_NEG, 64'd1);
    send_item(OP_DIV, 64'd7, '0);
    send_item(OP_DIV, MOST_NEG, '1);
    send_item(OP_DIV, -64'd7, 64'd2);
    send_item(OP_MOD, 64'd7, '0);
    send_item(OP_MOD, MOST_NEG, '1);
    send_item(OP_MOD, -64'd7, 64'd2);
    send_item(OP_OR, MOST_NEG, 64'd5);
    send_item(OP_AND, '1, MOST_POS);
    send_item(OP_XOR, '1, MOST_POS);
    send_item(OP_NOT, '0, '1);
    send_item(OP_NEG, MOST_NEG, '0);
    send_item(OP_NEG, MOST_POS, '0);
    send_item(4'd10, '1, '1);
    send_item(4'd15, '1, '1);
    wait_drain();
    for (int i = 0; i < 1650; i++) begin
      calm = (i >= 400 && i < 700);
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      send_item(op, pick_operand(), pick_operand());
    end
    wait_drain();
    repeat (100) @(posedge clk_i);
    if (scb.errors == 0 && scb.exp_res_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
